@@ src/ttrp_pkg.sv @@
package ttrp_pkg;

  localparam int FIELD_COUNT = 14;
  localparam int FIELD_ID_W  = 4;
  localparam int MAX_WORDS   = 9;
  localparam int WORD_CNT_W  = 6;

  localparam logic [7:0] POS_SRC     = 8'd16;
  localparam logic [7:0] POS_DST     = 8'd20;
  localparam logic [7:0] POS_PORT    = 8'd24;
  localparam logic [7:0] POS_CMD     = 8'd26;
  localparam logic [7:0] WORDS_START = 8'd28;
  localparam logic [7:0] POS_MAX     = 8'd255;

  localparam logic [2:0] OFF_KEY  = 3'd0;
  localparam logic [2:0] OFF_LAST = 3'd4;

  localparam logic [7:0] KEY_STOP       = 8'h00;
  localparam logic [7:0] KEY_TRAFFIC    = 8'h16;
  localparam logic [7:0] KEY_LEFT_RIGHT = 8'h1B;
  localparam logic [7:0] KEY_TOP_DOWN   = 8'h1C;
  localparam logic [7:0] KEY_SYSTIME    = 8'h04;
  localparam logic [7:0] KEY_NETTIME    = 8'h19;
  localparam logic [7:0] KEY_NET_BYTES  = 8'h0B;
  localparam logic [7:0] KEY_NET_STATE  = 8'h1D;
  localparam logic [7:0] KEY_SKIP       = 8'h1E;

  localparam int FID_SRC      = 0;
  localparam int FID_DST      = 1;
  localparam int FID_PORT     = 2;
  localparam int FID_CMD      = 3;
  localparam int FID_RECV     = 4;
  localparam int FID_SEND     = 5;
  localparam int FID_LEFT     = 6;
  localparam int FID_RIGHT    = 7;
  localparam int FID_TOP      = 8;
  localparam int FID_DOWN     = 9;
  localparam int FID_SYSTIME  = 10;
  localparam int FID_NETTIME  = 11;
  localparam int FID_NETSTATE = 12;
  localparam int FID_NETORDER = 13;
  localparam int FRAME_FIELDS = 10;

  localparam logic [FIELD_ID_W-1:0] LAST_ID = FIELD_ID_W'(FIELD_COUNT - 1);

  typedef logic [FIELD_COUNT-1:0][31:0] field_arr_t;

  typedef struct packed {
    logic       load;
    field_arr_t fields;
  } snap_t;

endpackage

@@ src/tail_time_reply_parser.sv @@
// Tail-time reply frame parser.
// Slave stream: one frame byte per request on s_tdata, s_tlast on the final
// byte. Master stream: after each frame, 14 field requests in id order, with
// the field value on m_tdata, its id on m_tuser and m_tlast on id 13.
// Bytes are registered on entry and parsed from there, one byte per clock
// while no final byte waits on the dump; a frame of 15 bytes or more is
// taken at full rate with no gaps if the receiver never stalls. m_tvalid
// rises once the parser takes a frame's final byte and the dump loads; the
// dump then gives one field per cycle while the receiver does not stall.
// While a dump is under way, body bytes of the next frame are still taken;
// only a final byte waits in the entry register until the dump has drained,
// so a stalled receiver or a frame shorter than the dump holds back the
// input only at the next frame end.
// Reset clears the byte position, word state and all 14 fields, and drops
// any dump in progress. Fields 10 to 13 keep their values across frames.
module tail_time_reply_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] field_value
  output logic [ttrp_pkg::FIELD_ID_W-1:0] m_tuser,   // [3:0] field_id
  output logic        m_tlast
);
  import ttrp_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       take;
  logic       busy;
  snap_t      snap;

  assign take = in_valid && (!in_last || !busy);

  ttrp_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .take     (take)
  );

  ttrp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .valid     (take),
    .data_byte (in_byte),
    .frame_end (in_last),
    .snap      (snap)
  );

  ttrp_dump u_dump (
    .clk      (clk),
    .rst      (rst),
    .snap     (snap),
    .busy     (busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ src/ttrp_in_reg.sv @@
module ttrp_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,
  output logic       in_valid,
  output logic [7:0] in_byte,
  output logic       in_last,
  input  logic       take
);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  assign s_tready = !in_valid || take;

endmodule

@@ src/ttrp_parser.sv @@
module ttrp_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid,
  input  logic [7:0]   data_byte,
  input  logic         frame_end,
  output ttrp_pkg::snap_t snap
);
  import ttrp_pkg::*;

  logic [7:0]            byte_position, byte_position_next;
  logic [2:0]            word_off, word_off_next;
  logic [7:0]            word_key, word_key_next;
  logic [31:0]           word_data, word_data_next;
  logic                  parse_stopped, parse_stopped_next;
  logic [WORD_CNT_W-1:0] words_seen, words_seen_next;
  field_arr_t            field_store, field_store_next;

  logic [7:0]            key_e;
  logic [31:0]           data_e;
  logic                  stop_e;
  logic [WORD_CNT_W-1:0] words_e;
  logic [1:0]            lane;

  always_comb begin
    field_store_next = field_store;
    key_e            = word_key;
    data_e           = word_data;
    stop_e           = parse_stopped;
    words_e          = words_seen;
    if (byte_position == '0) begin
      for (int i = 0; i < FRAME_FIELDS; i++) begin
        field_store_next[i] = '0;
      end
      key_e   = '0;
      data_e  = '0;
      stop_e  = 1'b0;
      words_e = '0;
    end
    word_key_next      = key_e;
    word_data_next     = data_e;
    parse_stopped_next = stop_e;
    words_seen_next    = words_e;
    lane               = word_off[1:0] - 2'd1;

    if (byte_position >= POS_SRC && byte_position < POS_DST) begin
      field_store_next[FID_SRC] = field_store_next[FID_SRC]
        | ({24'b0, data_byte} << {byte_position[1:0], 3'b000});
    end else if (byte_position >= POS_DST && byte_position < POS_PORT) begin
      field_store_next[FID_DST] = field_store_next[FID_DST]
        | ({24'b0, data_byte} << {byte_position[1:0], 3'b000});
    end else if (byte_position >= POS_PORT && byte_position < POS_CMD) begin
      field_store_next[FID_PORT] = field_store_next[FID_PORT]
        | ({24'b0, data_byte} << {byte_position[0], 3'b000});
    end else if (byte_position >= POS_CMD && byte_position < WORDS_START) begin
      field_store_next[FID_CMD] = field_store_next[FID_CMD]
        | ({24'b0, data_byte} << {byte_position[0], 3'b000});
    end else if (byte_position >= WORDS_START && !stop_e
                 && words_e < WORD_CNT_W'(MAX_WORDS)) begin
      if (word_off == OFF_KEY) begin
        word_key_next  = data_byte;
        word_data_next = '0;
        if (data_byte == KEY_STOP) begin
          parse_stopped_next = 1'b1;
        end
      end else begin
        word_data_next = data_e | ({24'b0, data_byte} << {lane, 3'b000});
        if (word_off == OFF_LAST) begin
          words_seen_next = words_e + 1'b1;
          case (key_e)
            KEY_TRAFFIC: begin
              field_store_next[FID_RECV] = {16'b0, word_data_next[15:0]};
              field_store_next[FID_SEND] = {16'b0, word_data_next[31:16]};
            end
            KEY_LEFT_RIGHT: begin
              field_store_next[FID_LEFT]  = {16'b0, word_data_next[31:16]};
              field_store_next[FID_RIGHT] = {16'b0, word_data_next[15:0]};
            end
            KEY_TOP_DOWN: begin
              field_store_next[FID_TOP]  = {16'b0, word_data_next[31:16]};
              field_store_next[FID_DOWN] = {16'b0, word_data_next[15:0]};
            end
            KEY_SYSTIME: field_store_next[FID_SYSTIME] = word_data_next;
            KEY_NETTIME: field_store_next[FID_NETTIME] = word_data_next;
            KEY_NET_BYTES: begin
              field_store_next[FID_NETSTATE] = {24'b0, word_data_next[7:0]};
              field_store_next[FID_NETORDER] = {24'b0, word_data_next[15:8]};
            end
            KEY_NET_STATE: field_store_next[FID_NETSTATE] = word_data_next;
            KEY_SKIP: ;
            default: ;
          endcase
        end
      end
    end

    if (frame_end) begin
      byte_position_next = '0;
      word_off_next      = OFF_KEY;
    end else if (byte_position < POS_MAX) begin
      byte_position_next = byte_position + 8'd1;
      if (byte_position >= WORDS_START) begin
        word_off_next = (word_off == OFF_LAST) ? OFF_KEY : word_off + 3'd1;
      end else begin
        word_off_next = word_off;
      end
    end else begin
      byte_position_next = byte_position;
      word_off_next      = word_off;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      word_off      <= OFF_KEY;
      word_key      <= '0;
      word_data     <= '0;
      parse_stopped <= 1'b0;
      words_seen    <= '0;
      field_store   <= '0;
    end else if (valid) begin
      byte_position <= byte_position_next;
      word_off      <= word_off_next;
      word_key      <= word_key_next;
      word_data     <= word_data_next;
      parse_stopped <= parse_stopped_next;
      words_seen    <= words_seen_next;
      field_store   <= field_store_next;
    end
  end

  assign snap.load   = valid && frame_end;
  assign snap.fields = field_store_next;

endmodule

@@ src/ttrp_dump.sv @@
module ttrp_dump (
  input  logic         clk,
  input  logic         rst,
  input  ttrp_pkg::snap_t snap,
  output logic         busy,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // [31:0] field_value
  output logic [ttrp_pkg::FIELD_ID_W-1:0] m_tuser,   // [3:0] field_id
  output logic         m_tlast
);
  import ttrp_pkg::*;

  field_arr_t            dump_buf;
  logic [FIELD_ID_W-1:0] dump_id;
  logic                  active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= 1'b0;
      dump_id <= '0;
    end else if (snap.load) begin
      active  <= 1'b1;
      dump_id <= '0;
    end else if (active && m_tready) begin
      dump_id <= dump_id + 1'b1;
      if (dump_id == LAST_ID) begin
        active <= 1'b0;
      end
    end
  end

  // shift down so that the head is always the field on show
  always_ff @(posedge clk) begin
    if (snap.load) begin
      dump_buf <= snap.fields;
    end else if (active && m_tready) begin
      for (int i = 0; i < FIELD_COUNT - 1; i++) begin
        dump_buf[i] <= dump_buf[i+1];
      end
    end
  end

  assign busy     = active;
  assign m_tvalid = active;
  assign m_tdata  = dump_buf[0];
  assign m_tuser  = dump_id;
  assign m_tlast  = (dump_id == LAST_ID);

endmodule

@@ test/tb_tail_time_reply_parser.sv @@
`timescale 1ns / 1ps

module tb_tail_time_reply_parser;
  import ttrp_pkg::*;

  localparam int HDR_LEN    = 28;
  localparam int RAND_BYTES = 450;

  typedef struct {
    logic [FIELD_ID_W-1:0] id;
    logic [31:0]           value;
    logic                  last;
  } field_rec_t;

  // Tracks the parser state and the field dump each frame end should produce.
  class reply_decoder;
    logic [7:0]  pos;
    logic [7:0]  key;
    logic [31:0] word;
    bit          stopped;
    logic [5:0]  nwords;
    logic [31:0] fields [FIELD_COUNT];
    field_rec_t  pending_fields [$];
    int          mismatches;
    int          frames;
    int          fields_checked;

    function new();
      pos = '0;
      key = '0;
      word = '0;
      stopped = 0;
      nwords = '0;
      foreach (fields[i]) fields[i] = '0;
      mismatches = 0;
      frames = 0;
      fields_checked = 0;
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int         off;
      field_rec_t rec;
      if (pos == 0) begin
        for (int i = 0; i < FRAME_FIELDS; i++) fields[i] = '0;
        stopped = 0;
        nwords = '0;
        key = '0;
        word = '0;
      end
      if (pos >= POS_SRC && pos < POS_DST) begin
        fields[FID_SRC] |= 32'(b) << (8 * (pos - POS_SRC));
      end else if (pos >= POS_DST && pos < POS_PORT) begin
        fields[FID_DST] |= 32'(b) << (8 * (pos - POS_DST));
      end else if (pos >= POS_PORT && pos < POS_CMD) begin
        fields[FID_PORT] |= 32'(b) << (8 * (pos - POS_PORT));
      end else if (pos >= POS_CMD && pos < WORDS_START) begin
        fields[FID_CMD] |= 32'(b) << (8 * (pos - POS_CMD));
      end else if (pos >= WORDS_START && !stopped && nwords < MAX_WORDS) begin
        off = int'(pos - WORDS_START) % 5;
        if (off == OFF_KEY) begin
          key = b;
          word = '0;
          if (b == KEY_STOP) stopped = 1;
        end else begin
          word |= 32'(b) << (8 * (off - 1));
          if (off == OFF_LAST) begin
            // left/right and top/down take the high half first
            case (key)
              KEY_TRAFFIC: begin
                fields[FID_RECV] = {16'b0, word[15:0]};
                fields[FID_SEND] = {16'b0, word[31:16]};
              end
              KEY_LEFT_RIGHT: begin
                fields[FID_LEFT]  = {16'b0, word[31:16]};
                fields[FID_RIGHT] = {16'b0, word[15:0]};
              end
              KEY_TOP_DOWN: begin
                fields[FID_TOP]  = {16'b0, word[31:16]};
                fields[FID_DOWN] = {16'b0, word[15:0]};
              end
              KEY_SYSTIME: fields[FID_SYSTIME] = word;
              KEY_NETTIME: fields[FID_NETTIME] = word;
              KEY_NET_BYTES: begin
                fields[FID_NETSTATE] = {24'b0, word[7:0]};
                fields[FID_NETORDER] = {24'b0, word[15:8]};
              end
              KEY_NET_STATE: fields[FID_NETSTATE] = word;
              default: ;
            endcase
            nwords++;
          end
        end
      end
      if (pos != POS_MAX) pos++;
      if (last) begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
          rec.id    = FIELD_ID_W'(i);
          rec.value = fields[i];
          rec.last  = (i == FIELD_COUNT - 1);
          pending_fields.push_back(rec);
        end
        frames++;
        pos = '0;
      end
    endfunction

    function void check_field(logic [FIELD_ID_W-1:0] id, logic [31:0] value, logic last);
      field_rec_t exp_rec;
      if (pending_fields.size() == 0) begin
        $display("%0t: unexpected field request id %0d value %h", $time, id, value);
        mismatches++;
        return;
      end
      exp_rec = pending_fields.pop_front();
      fields_checked++;
      if (id !== exp_rec.id) begin
        $display("%0t: field_id expected %0d, got %0d", $time, exp_rec.id, id);
        mismatches++;
      end
      if (value !== exp_rec.value) begin
        $display("%0t: field %0d value expected %h, got %h", $time, exp_rec.id,
                 exp_rec.value, value);
        mismatches++;
      end
      if (last !== exp_rec.last) begin
        $display("%0t: field %0d last expected %b, got %b", $time, exp_rec.id,
                 exp_rec.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [31:0]           m_tdata;
  logic [FIELD_ID_W-1:0] m_tuser;
  logic                  m_tlast;

  reply_decoder decoder;
  logic [7:0]   frame_bytes [$];
  int           burst_left = 0;
  int           byte_reqs = 0;
  int           stall_cycle = 0;

  tail_time_reply_parser i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [7:0] data_byte
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [31:0] field_value
    .m_tuser  (m_tuser),    // [3:0] field_id
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall pattern steps through always ready, mostly ready, mostly stalled and a square wave.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) decoder.check_field(m_tuser, m_tdata, m_tlast);
      stall_cycle++;
      case ((stall_cycle / 97) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= stall_cycle[2];
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    decoder.take_byte(b, last);
    burst_left--;
    byte_reqs++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[k]) send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
    frame_bytes.delete();
  endtask

  // style: 0 random, 1 all ones, 2 all zeros
  function automatic void push_header(int style);
    for (int i = 0; i < HDR_LEN; i++) begin
      case (style)
        1: frame_bytes.push_back(8'hFF);
        2: frame_bytes.push_back(8'h00);
        default: frame_bytes.push_back(8'($urandom));
      endcase
    end
  endfunction

  function automatic void push_word(logic [7:0] k, logic [31:0] d);
    frame_bytes.push_back(k);
    frame_bytes.push_back(d[7:0]);
    frame_bytes.push_back(d[15:8]);
    frame_bytes.push_back(d[23:16]);
    frame_bytes.push_back(d[31:24]);
  endfunction

  function automatic logic [7:0] pick_key();
    logic [7:0] known [7] = '{KEY_TRAFFIC, KEY_LEFT_RIGHT, KEY_TOP_DOWN, KEY_SYSTIME,
                              KEY_NETTIME, KEY_NET_BYTES, KEY_NET_STATE};
    int r;
    r = $urandom_range(0, 15);
    if (r < 14) return known[r % 7];
    if (r == 14) return $urandom_range(0, 1) ? KEY_SKIP : 8'($urandom);
    return KEY_STOP;
  endfunction

  function automatic void build_reply(int nwords);
    int r;
    r = $urandom_range(0, 9);
    push_header(r == 0 ? 1 : (r == 1 ? 2 : 0));
    for (int i = 0; i < nwords; i++) push_word(pick_key(), $urandom);
  endfunction

  initial begin
    int  kind;
    int  cut;
    int  total_len;
    bit  long_done;
    decoder = new();
    long_done = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // one-byte frame: ends at position zero
    frame_bytes.push_back(8'hFF);
    send_frame();

    // every key but the stop key, with the skip key and an unknown key filling the word limit
    push_header(1);
    push_word(KEY_TRAFFIC,    32'hFFFF_0001);
    push_word(KEY_LEFT_RIGHT, 32'h0002_FFFF);
    push_word(KEY_TOP_DOWN,   32'h8000_0003);
    push_word(KEY_SYSTIME,    32'hFFFF_FFFF);
    push_word(KEY_NETTIME,    32'h8765_4321);
    push_word(KEY_SKIP,       32'hFFFF_FFFF);
    push_word(8'hFF,          32'h0000_0000);
    push_word(KEY_NET_STATE,  32'h1234_5678);
    push_word(KEY_NET_BYTES,  32'hFFFF_A55A);
    push_word(KEY_SYSTIME,    32'h0000_0000);  // beyond the limit
    send_frame();

    // cut-off word is dropped
    push_header(2);
    push_word(KEY_NET_STATE, 32'hFFFF_FFFF);
    push_word(KEY_NETTIME, 32'h0);
    void'(frame_bytes.pop_back());
    send_frame();

    // zero key halts parsing
    push_header(0);
    push_word(KEY_STOP, 32'hFFFF_FFFF);
    push_word(KEY_SYSTIME, 32'h0);
    send_frame();

    while (byte_reqs < RAND_BYTES) begin
      kind = $urandom_range(0, 11);
      if (!long_done && byte_reqs > 150) kind = 11;
      if (kind == 0) begin
        repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      end else if (kind == 11 && !long_done) begin
        // runs past the saturation point of the byte position
        build_reply(MAX_WORDS);
        total_len = $urandom_range(256, 300);
        while (frame_bytes.size() < total_len) frame_bytes.push_back(8'($urandom));
        long_done = 1;
      end else begin
        build_reply($urandom_range(0, MAX_WORDS + 2));
        if ($urandom_range(0, 3) == 0) begin
          cut = $urandom_range(1, frame_bytes.size());
          while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
      end
      send_frame();
    end
    s_tvalid <= 1'b0;

    while (decoder.pending_fields.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoder.pending_fields.size() != 0) begin
      $display("%0t: %0d field requests never arrived", $time,
               decoder.pending_fields.size());
      decoder.mismatches++;
    end

    $display("Sent %0d frames in %0d byte requests: all keys, stop, cut-off, long frame",
             decoder.frames, byte_reqs);
    $display("Checked %0d field requests, %0d mismatches", decoder.fields_checked,
             decoder.mismatches);
    if (decoder.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
